>>> rtl/core/fmpd_pkg.sv
// Package for the FM phase discriminator.
// Holds the CORDIC datapath width, the stage control struct and the arctangent table.
// No dependencies.
`default_nettype none

package fmpd_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_BITS = 20;
  localparam int SAMPLE_W = 8;
  localparam int DELTA_W = 16;
  localparam int TABLE_LEN = 24;
  localparam int PHASE_BITS_DEFAULT = 16;
  localparam int CORDIC_STAGES_DEFAULT = 16;
  localparam logic [SAMPLE_W-1:0] DC_OFFSET_RESET = 8'd128;

  typedef struct packed {
    logic valid;
    logic start;
    logic zero;
  } stage_ctrl_t;

  // atan(2^-k) as a fraction of a full turn, 32 fractional bits
  localparam logic [31:0] ATAN_TURN32 [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // table entry rounded half up to pb bits of a turn
  function automatic logic [31:0] atan_entry(input int k, input int pb);
    int s;
    logic [32:0] e;
    s = 32 - pb;
    e = {1'b0, ATAN_TURN32[k]} + (33'd1 << (s - 1));
    return 32'(e >> s);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/fm_phase_discriminator.sv
// FM phase discriminator top level: front stage, CORDIC cell chain, difference stage.
// Depends on fmpd_pkg, fmpd_front, fmpd_cordic_cell, fmpd_diff.
//
// Usage:
//   Sample channel (sample_valid / sample_stall) carries one raw I/Q byte pair per
//   beat plus block_start. Result channel (delta_valid / delta_stall) carries the
//   signed 16-bit phase change since the previous pair, pi = 32768. A pair marked
//   block_start, and the first pair after reset, only stores its angle.
//   The dc_offset register is written on the dc_valid / dc_ready channel; dc_ready
//   is always high. Write it only while the pipeline is empty.
//   The pipeline has one front register, one register per CORDIC cell and one
//   output register. Throughput is one pair per cycle while the output is not stalled.
//   The whole pipeline moves on a single enable; when the output register holds
//   a result and delta_stall is high, every stage holds and sample_stall is high.
//   Reset (synchronous) empties the pipeline, clears the stored angle and sets
//   dc_offset to 128.
`default_nettype none

module fm_phase_discriminator
  import fmpd_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEFAULT,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      dc_valid,
  output logic                           dc_ready,
  input  wire logic [SAMPLE_W-1:0]       dc_offset,
  input  wire logic                      sample_valid,
  output logic                           sample_stall,
  input  wire logic [SAMPLE_W-1:0]       i_sample,
  input  wire logic [SAMPLE_W-1:0]       q_sample,
  input  wire logic                      block_start,
  output logic                           delta_valid,
  input  wire logic                      delta_stall,
  output logic signed [DELTA_W-1:0]      phase_delta
);

  logic en;
  stage_ctrl_t              ctrl [CORDIC_STAGES+1];
  logic signed [DATA_W-1:0] x    [CORDIC_STAGES+1];
  logic signed [DATA_W-1:0] y    [CORDIC_STAGES+1];
  logic [PHASE_BITS-1:0]    z    [CORDIC_STAGES+1];

  assign en = !(delta_valid && delta_stall);
  assign sample_stall = !en;
  assign dc_ready = 1'b1;

  fmpd_front #(
    .PHASE_BITS(PHASE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .dc_write   (dc_valid && dc_ready),
    .dc_data    (dc_offset),
    .beat       (sample_valid && en),
    .i_sample   (i_sample),
    .q_sample   (q_sample),
    .block_start(block_start),
    .ctrl       (ctrl[0]),
    .x          (x[0]),
    .y          (y[0]),
    .z          (z[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    fmpd_cordic_cell #(
      .PHASE_BITS(PHASE_BITS),
      .STAGE     (k)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .ctrl_in(ctrl[k]),
      .x_in   (x[k]),
      .y_in   (y[k]),
      .z_in   (z[k]),
      .ctrl   (ctrl[k+1]),
      .x      (x[k+1]),
      .y      (y[k+1]),
      .z      (z[k+1])
    );
  end

  fmpd_diff #(
    .PHASE_BITS(PHASE_BITS)
  ) u_diff (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .ctrl_in    (ctrl[CORDIC_STAGES]),
    .z_in       (z[CORDIC_STAGES]),
    .delta_valid(delta_valid),
    .phase_delta(phase_delta)
  );

endmodule

`default_nettype wire

>>> rtl/core/fmpd_front.sv
// Input stage: DC offset register, centering and half-plane pre-rotation.
// Depends on fmpd_pkg.
`default_nettype none

module fmpd_front
  import fmpd_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         dc_write,
  input  wire logic [SAMPLE_W-1:0]          dc_data,
  input  wire logic                         beat,
  input  wire logic [SAMPLE_W-1:0]          i_sample,
  input  wire logic [SAMPLE_W-1:0]          q_sample,
  input  wire logic                         block_start,
  output stage_ctrl_t                       ctrl,
  output logic signed [DATA_W-1:0]          x,
  output logic signed [DATA_W-1:0]          y,
  output logic        [PHASE_BITS-1:0]      z
);

  logic [SAMPLE_W-1:0] dc;
  logic signed [SAMPLE_W:0] ci;
  logic signed [SAMPLE_W:0] cq;
  logic signed [DATA_W-1:0] xs;
  logic signed [DATA_W-1:0] ys;
  logic left;

  always_ff @(posedge clk) begin
    if (rst) begin
      dc <= DC_OFFSET_RESET;
    end else if (dc_write) begin
      dc <= dc_data;
    end
  end

  always_comb begin
    ci = $signed({1'b0, i_sample}) - $signed({1'b0, dc});
    cq = $signed({1'b0, q_sample}) - $signed({1'b0, dc});
    xs = DATA_W'(cq) <<< FRAC_BITS;
    ys = DATA_W'(ci) <<< FRAC_BITS;
    left = cq[SAMPLE_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (en) begin
      ctrl.valid <= beat;
      ctrl.start <= block_start;
      ctrl.zero  <= (ci == '0) && (cq == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x <= left ? -xs : xs;
      y <= left ? -ys : ys;
      z <= left ? {1'b1, {(PHASE_BITS-1){1'b0}}} : '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/fmpd_cordic_cell.sv
// One vectoring CORDIC cell: a fixed shift, add/subtract and table angle.
// Depends on fmpd_pkg.
`default_nettype none

module fmpd_cordic_cell
  import fmpd_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEFAULT,
  parameter int STAGE = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire stage_ctrl_t                  ctrl_in,
  input  wire logic signed [DATA_W-1:0]     x_in,
  input  wire logic signed [DATA_W-1:0]     y_in,
  input  wire logic        [PHASE_BITS-1:0] z_in,
  output stage_ctrl_t                       ctrl,
  output logic signed [DATA_W-1:0]          x,
  output logic signed [DATA_W-1:0]          y,
  output logic        [PHASE_BITS-1:0]      z
);

  localparam logic [PHASE_BITS-1:0] ANGLE = PHASE_BITS'(atan_entry(STAGE, PHASE_BITS));

  logic signed [DATA_W-1:0] xs;
  logic signed [DATA_W-1:0] ys;
  logic y_neg;

  always_comb begin
    xs = x_in >>> STAGE;
    ys = y_in >>> STAGE;
    y_neg = y_in[DATA_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (en) begin
      ctrl <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x <= y_neg ? x_in - ys : x_in + ys;
      y <= y_neg ? y_in + xs : y_in - xs;
      z <= y_neg ? z_in - ANGLE : z_in + ANGLE;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/fmpd_diff.sv
// Output stage: angle to 16 bits, difference from the previous angle, output register.
// Depends on fmpd_pkg.
`default_nettype none

module fmpd_diff
  import fmpd_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire stage_ctrl_t                  ctrl_in,
  input  wire logic        [PHASE_BITS-1:0] z_in,
  output logic                              delta_valid,
  output logic signed [DELTA_W-1:0]         phase_delta
);

  logic [DELTA_W-1:0] angle;
  logic [DELTA_W-1:0] ph;
  logic [DELTA_W-1:0] previous_phase;
  logic have_previous;

  if (PHASE_BITS >= DELTA_W) begin : g_trunc
    assign angle = z_in[PHASE_BITS-1 -: DELTA_W];
  end else begin : g_widen
    assign angle = DELTA_W'(z_in) << (DELTA_W - PHASE_BITS);
  end

  assign ph = ctrl_in.zero ? '0 : angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_valid <= 1'b0;
      have_previous <= 1'b0;
      previous_phase <= '0;
    end else if (en) begin
      delta_valid <= ctrl_in.valid && !ctrl_in.start && have_previous;
      if (ctrl_in.valid) begin
        have_previous <= 1'b1;
        previous_phase <= ph;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phase_delta <= $signed(ph - previous_phase);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/fmpd_checker.sv
// Port-level checker for fm_phase_discriminator, bound to the top level.
// Depends on fmpd_pkg.
`default_nettype none

module fmpd_checker
  import fmpd_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     sample_stall,
  input wire logic                     delta_valid,
  input wire logic                     delta_stall,
  input wire logic signed [DELTA_W-1:0] phase_delta
);

  // held result beat
  assert property (@(posedge clk) disable iff (rst)
    delta_valid && delta_stall |=> delta_valid && $stable(phase_delta))
    else $error("result beat changed while stalled");

  // input only backs up when the output is blocked
  assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> delta_valid && delta_stall)
    else $error("sample stall without a blocked result");

  // reset empties the pipeline
  assert property (@(posedge clk)
    rst |=> !delta_valid && !sample_stall)
    else $error("pipeline not empty after reset");

endmodule

bind fm_phase_discriminator fmpd_checker u_fmpd_checker (
  .clk         (clk),
  .rst         (rst),
  .sample_stall(sample_stall),
  .delta_valid (delta_valid),
  .delta_stall (delta_stall),
  .phase_delta (phase_delta)
);

`default_nettype wire

>>> verif/tb_fm_phase_discriminator.sv
// Self-checking testbench for fm_phase_discriminator: I/Q beats in, phase deltas out,
// with a bit-exact CORDIC angle predictor, random idling and back-pressure.
// Depends on fmpd_pkg and the fm_phase_discriminator RTL.
`default_nettype none

module tb_fm_phase_discriminator;
  import fmpd_pkg::*;

  localparam int STAGES = 16;
  localparam int DRAIN_CYCLES = STAGES + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int MAX_GAP = 40;
  localparam int PHASE_ITEMS = 215;

  // atan(2^-k) in turns, 32 fractional bits
  localparam logic [31:0] ARCTAN_TURNS [STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_VALUE} row_kind_e;

  typedef struct packed {
    logic [7:0]  dc;
    logic [7:0]  i;
    logic [7:0]  q;
    logic        st;
    row_kind_e   kind;
    logic [15:0] val;
  } probe_row_t;

  localparam int NUM_ROWS = 25;
  localparam probe_row_t DIRECTED [NUM_ROWS] = '{
    '{8'd128, 8'd128, 8'd128, 1'b0, ROW_NONE,    16'h0000},
    '{8'd128, 8'd128, 8'd128, 1'b0, ROW_VALUE,   16'h0000},
    '{8'd128, 8'd255, 8'd128, 1'b0, ROW_PREDICT, 16'h0000},
    '{8'd128, 8'd0,   8'd128, 1'b0, ROW_PREDICT, 16'h0000},
    '{8'd128, 8'd128, 8'd0,   1'b0, ROW_PREDICT, 16'h0000},
    '{8'd128, 8'd0,   8'd0,   1'b0, ROW_PREDICT, 16'h0000},
    '{8'd128, 8'd255, 8'd255, 1'b0, ROW_PREDICT, 16'h0000},
    '{8'd128, 8'd0,   8'd255, 1'b0, ROW_PREDICT, 16'h0000},
    '{8'd128, 8'd255, 8'd0,   1'b0, ROW_PREDICT, 16'h0000},
    '{8'd128, 8'd128, 8'd255, 1'b0, ROW_PREDICT, 16'h0000},
    '{8'd128, 8'd170, 8'd85,  1'b1, ROW_NONE,    16'h0000},
    '{8'd128, 8'd85,  8'd170, 1'b0, ROW_PREDICT, 16'h0000},
    '{8'd128, 8'd129, 8'd128, 1'b0, ROW_PREDICT, 16'h0000},
    '{8'd128, 8'd128, 8'd127, 1'b0, ROW_PREDICT, 16'h0000},
    '{8'd0,   8'd0,   8'd0,   1'b1, ROW_NONE,    16'h0000},
    '{8'd0,   8'd0,   8'd0,   1'b0, ROW_VALUE,   16'h0000},
    '{8'd0,   8'd255, 8'd0,   1'b0, ROW_PREDICT, 16'h0000},
    '{8'd0,   8'd0,   8'd255, 1'b0, ROW_PREDICT, 16'h0000},
    '{8'd0,   8'd255, 8'd255, 1'b0, ROW_PREDICT, 16'h0000},
    '{8'd255, 8'd255, 8'd255, 1'b1, ROW_NONE,    16'h0000},
    '{8'd255, 8'd255, 8'd255, 1'b0, ROW_VALUE,   16'h0000},
    '{8'd255, 8'd0,   8'd0,   1'b0, ROW_PREDICT, 16'h0000},
    '{8'd255, 8'd0,   8'd255, 1'b0, ROW_PREDICT, 16'h0000},
    '{8'd255, 8'd255, 8'd0,   1'b0, ROW_PREDICT, 16'h0000},
    '{8'd255, 8'd254, 8'd255, 1'b0, ROW_PREDICT, 16'h0000}
  };

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      dc_valid = 1'b0;
  logic                      dc_ready;
  logic [SAMPLE_W-1:0]       dc_offset = 8'd0;
  logic                      sample_valid = 1'b0;
  logic                      sample_stall;
  logic [SAMPLE_W-1:0]       i_sample = 8'd0;
  logic [SAMPLE_W-1:0]       q_sample = 8'd0;
  logic                      block_start = 1'b0;
  logic                      delta_valid;
  logic                      delta_stall = 1'b0;
  logic signed [DELTA_W-1:0] phase_delta;

  logic [15:0] pending_deltas [$];
  logic [7:0]  dc_level = DC_OFFSET_RESET;
  logic [15:0] last_angle = 16'h0000;
  logic        have_angle = 1'b0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          tx_pct = 0;
  int          rx_pct = 0;
  int          hold_reqs = 0;
  int          hold_grants = 0;
  int          hold_left = 0;

  fm_phase_discriminator u_dut (
    .clk          (clk),
    .rst          (rst),
    .dc_valid     (dc_valid),
    .dc_ready     (dc_ready),
    .dc_offset    (dc_offset),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .i_sample     (i_sample),
    .q_sample     (q_sample),
    .block_start  (block_start),
    .delta_valid  (delta_valid),
    .delta_stall  (delta_stall),
    .phase_delta  (phase_delta)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] arctan_step(input int k);
    logic [32:0] e;
    e = {1'b0, ARCTAN_TURNS[k]} + 33'h8000;
    return e[31:16];
  endfunction

  // vectoring CORDIC, Q on x, I on y, 16-bit binary angle
  function automatic logic [15:0] cordic_angle(input logic [7:0] i_raw, input logic [7:0] q_raw,
                                               input logic [7:0] dc);
    int          ci;
    int          cq;
    longint      x;
    longint      y;
    longint      xs;
    longint      ys;
    logic [15:0] z;
    ci = int'(i_raw) - int'(dc);
    cq = int'(q_raw) - int'(dc);
    if (ci == 0 && cq == 0) return 16'h0000;
    x = longint'(cq) <<< 20;
    y = longint'(ci) <<< 20;
    z = 16'h0000;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 16'h8000;
    end
    for (int k = 0; k < STAGES; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_step(k);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_step(k);
      end
    end
    return z;
  endfunction

  function automatic logic [7:0] pick_byte(input logic [7:0] dc);
    int v;
    if ($urandom_range(9) < 7) return 8'($urandom_range(255));
    v = int'(dc) + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  task automatic send_pair(input logic [7:0] i_raw, input logic [7:0] q_raw, input logic st,
                           input row_kind_e kind, input logic [15:0] val);
    int          gap;
    logic [15:0] ang;
    logic [15:0] delta;
    logic        yields;
    gap = 0;
    while (tx_pct != 0 && gap < MAX_GAP && int'($urandom_range(99)) < tx_pct) gap++;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    i_sample <= i_raw;
    q_sample <= q_raw;
    block_start <= st;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    ang = cordic_angle(i_raw, q_raw, dc_level);
    yields = !st && have_angle;
    delta = ang - last_angle;
    last_angle = ang;
    have_angle = 1'b1;
    case (kind)
      ROW_PREDICT: if (yields) pending_deltas.push_back(delta);
      ROW_VALUE:   pending_deltas.push_back(val);
      default:     ;
    endcase
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    do @(posedge clk); while (pending_deltas.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dc(input logic [7:0] v);
    dc_valid <= 1'b1;
    dc_offset <= v;
    do @(posedge clk); while (!dc_ready);
    dc_valid <= 1'b0;
    dc_level = v;
  endtask

  task automatic log_miss(input string what, input logic [15:0] want, input logic [15:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d: %s, expected %0d, got %0d", mismatches, what, $signed(want),
               $signed(got));
  endtask

  always @(posedge clk) begin
    if (!rst && delta_valid && !delta_stall) begin
      if (pending_deltas.size() == 0) begin
        log_miss("unexpected phase_delta beat", 16'hxxxx, phase_delta);
      end else begin
        if (pending_deltas[0] !== phase_delta) log_miss("phase_delta", pending_deltas[0], phase_delta);
        void'(pending_deltas.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      delta_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_grants) begin
      hold_grants <= hold_grants + 1;
      hold_left <= HOLD_CYCLES;
      delta_stall <= 1'b1;
    end else begin
      delta_stall <= (rx_pct != 0) && (int'($urandom_range(99)) < rx_pct);
    end
  end

  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (delta_valid && !delta_stall) || (dc_valid && dc_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int         sent;
    int         run_len;
    logic       ragged;
    logic       st;
    logic [7:0] dc_next;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED[r].dc != dc_level) begin
        drain();
        write_dc(DIRECTED[r].dc);
      end
      send_pair(DIRECTED[r].i, DIRECTED[r].q, DIRECTED[r].st, DIRECTED[r].kind, DIRECTED[r].val);
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin dc_next = 8'($urandom_range(255)); tx_pct = 0;  rx_pct = 0;  end
        1: begin dc_next = 8'd0;                    tx_pct = 55; rx_pct = 0;  end
        2: begin dc_next = 8'd255;                  tx_pct = 0;  rx_pct = 55; end
        3: begin dc_next = 8'($urandom_range(255)); tx_pct = 10; rx_pct = 10; end
        4: begin dc_next = 8'd128;                  tx_pct = 0;  rx_pct = 0;  end
        default: begin dc_next = 8'($urandom_range(255)); tx_pct = 10; rx_pct = 10; end
      endcase
      write_dc(dc_next);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        run_len = $urandom_range(1, 40);
        ragged = ($urandom_range(7) == 0);
        for (int j = 0; j < run_len; j++) begin
          // long receiver hold-off while beats keep coming
          if (ph == 4 && sent % 70 == 10) hold_reqs++;
          st = ragged ? 1'($urandom_range(1)) : (j == 0);
          send_pair(pick_byte(dc_level), pick_byte(dc_level), st, ROW_PREDICT, 16'h0000);
          sent++;
        end
        if (ph == 5 && $urandom_range(3) == 0) begin
          sample_valid <= 1'b0;
          do @(posedge clk); while (pending_deltas.size() != 0);
        end
      end
    end

    drain();
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/fmpd_pkg.sv
rtl/core/fmpd_front.sv
rtl/core/fmpd_cordic_cell.sv
rtl/core/fmpd_diff.sv
rtl/core/fm_phase_discriminator.sv
rtl/core/fmpd_checker.sv
verif/tb_fm_phase_discriminator.sv
